// ===== hdl/rct_pkg.sv =====
// shared types, constants and helpers for the reference count table
// no dependencies
`default_nettype none

package rct_pkg;

    localparam int ENTRIES     = 8;
    localparam int COUNT_BITS  = 8;
    localparam int HANDLE_BITS = 32;
    localparam int PORT_BITS   = 32;

    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [PORT_BITS-1:0]   port_handle_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic {
        KIND_ALLOC  = 1'b0,
        KIND_ASSIGN = 1'b1
    } kind_t;

    // command broadcast to every cell in the update cycle
    typedef struct packed {
        logic    fire;
        kind_t   kind;
        handle_t new_h;
        handle_t src_h;
        handle_t dst_h;
    } cell_cmd_t;

    // priority carry passed from one cell to the next
    typedef struct packed {
        logic alloc_done;
        logic rel_done;
        logic freed;
    } cell_carry_t;

    // port word to table handle: truncate or zero extend
    function automatic handle_t to_handle(input port_handle_t x);
        handle_t h;
        h = '0;
        for (int i = 0; i < HANDLE_BITS; i++) begin
            if (i < PORT_BITS) begin
                h[i] = x[i];
            end
        end
        return h;
    endfunction

    // table handle to port word
    function automatic port_handle_t to_port(input handle_t h);
        port_handle_t x;
        x = '0;
        for (int i = 0; i < PORT_BITS; i++) begin
            if (i < HANDLE_BITS) begin
                x[i] = h[i];
            end
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rct_cell.sv =====
// one table entry: handle and reference count with its slice of the priority chain
// depends on rct_pkg
`default_nettype none

module rct_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rct_pkg::cell_cmd_t   cmd,
    input  wire rct_pkg::cell_carry_t carry_in,
    output rct_pkg::cell_carry_t      carry_out
);

    rct_pkg::handle_t handle_reg, handle_next;
    rct_pkg::count_t  count_reg,  count_next;

    logic             take;
    logic             hit_src;
    logic             hit_dst;
    rct_pkg::handle_t rel_handle;
    rct_pkg::count_t  rel_count;

    always_comb begin
        take    = 1'b0;
        hit_src = 1'b0;
        hit_dst = 1'b0;
        rel_handle = handle_reg;
        rel_count  = count_reg;
        handle_next = handle_reg;
        count_next  = count_reg;
        carry_out   = carry_in;
        case (cmd.kind)
            rct_pkg::KIND_ALLOC: begin
                take = !carry_in.alloc_done && (count_reg == '0);
                carry_out.alloc_done = carry_in.alloc_done || take;
                if (take) begin
                    handle_next = cmd.new_h;
                    count_next  = rct_pkg::count_t'(1);
                end
            end
            rct_pkg::KIND_ASSIGN: begin
                // release: first entry holding the source
                hit_src = !carry_in.rel_done && (cmd.src_h != '0)
                          && (handle_reg == cmd.src_h);
                if (hit_src) begin
                    if (count_reg != '0) begin
                        rel_count = count_reg - rct_pkg::count_t'(1);
                    end
                    if (rel_count == '0) begin
                        rel_handle = '0;
                    end
                end
                carry_out.rel_done = carry_in.rel_done || hit_src;
                carry_out.freed    = carry_in.freed || (hit_src && (rel_count == '0));
                // retain: every entry still holding the destination
                hit_dst = (cmd.dst_h != '0) && (rel_handle == cmd.dst_h)
                          && (rel_count != rct_pkg::COUNT_MAX);
                handle_next = rel_handle;
                count_next  = hit_dst ? rel_count + rct_pkg::count_t'(1) : rel_count;
            end
            default: begin
                handle_next = handle_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            handle_reg <= '0;
            count_reg  <= '0;
        end else if (cmd.fire) begin
            handle_reg <= handle_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/reference_count_table_core.sv =====
// reference count table top level: input holding register, chain of entry cells,
// result register; depends on rct_pkg and rct_cell
//
// channel | dir | tdata (lsb first)                          | tuser (lsb first)
// s_      | in  | new_handle[31:0] src_handle dst_handle      | kind
// m_      | out | handle_out[31:0]                           | status, freed
//
// a word is taken into a holding register and, once the result slot is free,
// applied to all entries at once while the first-free / first-match flags ripple
// through the chain of cells; the result register is loaded at that edge
// a word passes the holding register, then the result register; one word per
// cycle sustained when the result side keeps up, set by the single update pass
// over the chain; reset (aresetn low, synchronous) clears every entry and the
// valid flags of the holding register and the result register
// a stalled result holds the held word back; the holding register is freed
// in the cycle its word is applied, so a new word can enter in that cycle
`default_nettype none

module reference_count_table_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // new_handle, src_handle, dst_handle
    input  wire logic         s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // handle_out
    output logic [1:0]        m_tuser    // status, freed
);

    // held word waiting for its update pass
    logic              busy_reg, busy_next;
    rct_pkg::kind_t    kind_reg;
    rct_pkg::handle_t  new_reg, src_reg, dst_reg;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    logic              fire;
    logic              s_take;
    rct_pkg::cell_cmd_t   cmd;
    rct_pkg::cell_carry_t carry [rct_pkg::ENTRIES+1];
    logic              full;
    rct_pkg::handle_t  res_handle;

    // update pass runs when a word is held and the result slot is free
    assign fire     = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        if (s_take) begin
            busy_next = 1'b1;
        end else if (fire) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_take) begin
            kind_reg <= rct_pkg::kind_t'(s_tuser);
            new_reg  <= rct_pkg::to_handle(s_tdata[31:0]);
            src_reg  <= rct_pkg::to_handle(s_tdata[63:32]);
            dst_reg  <= rct_pkg::to_handle(s_tdata[95:64]);
        end
    end

    always_comb begin
        cmd.fire  = fire;
        cmd.kind  = kind_reg;
        cmd.new_h = new_reg;
        cmd.src_h = src_reg;
        cmd.dst_h = dst_reg;
    end

    // chain head: nothing taken yet
    assign carry[0] = '0;

    for (genvar g = 0; g < rct_pkg::ENTRIES; g++) begin : g_cell
        rct_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .carry_in  (carry[g]),
            .carry_out (carry[g+1])
        );
    end

    // result from the chain tail
    always_comb begin
        full       = 1'b0;
        res_handle = dst_reg;
        case (kind_reg)
            rct_pkg::KIND_ALLOC: begin
                full       = !carry[rct_pkg::ENTRIES].alloc_done;
                res_handle = full ? '0 : new_reg;
            end
            rct_pkg::KIND_ASSIGN: begin
                res_handle = dst_reg;
            end
            default: begin
                res_handle = dst_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= rct_pkg::to_port(res_handle);
            m_user_reg <= {carry[rct_pkg::ENTRIES].freed && (kind_reg == rct_pkg::KIND_ASSIGN),
                           full};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // a full status always comes with a null handle and no release
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("full status with non-null handle or freed flag");

    // an update pass always leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("update pass produced no result");

    // a held word waits unchanged until its pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !fire |=> busy_reg && $stable(src_reg) && $stable(dst_reg)
                              && $stable(new_reg))
        else $error("held word lost or changed while stalled");

    // a release is only reported when a source entry was hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && carry[rct_pkg::ENTRIES].freed |-> carry[rct_pkg::ENTRIES].rel_done)
        else $error("freed flag without a matching source entry");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for reference_count_table_core: directed and random words with
// random idling on both channels, each result checked against a table predictor
// depends on rct_pkg and the reference_count_table_core rtl
`default_nettype none

module tb_top;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  POOL_SIZE   = 14;
    localparam int  RANDOM_WORDS = 1420;
    localparam int  REPORT_MAX  = 10;

    // one input word as it is queued for the driver
    typedef struct {
        rct_pkg::kind_t kind;
        logic [31:0]    new_h;
        logic [31:0]    src_h;
        logic [31:0]    dst_h;
        bit             hold_for_drain;   // wait until every owed result has come back
    } word_t;

    typedef struct {
        logic [31:0] handle_out;
        logic        status;
        logic        freed;
    } result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // slave side, driven by the bench
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;    // new_handle, src_handle, dst_handle
    logic        s_tuser  = 1'b0;  // kind

    // master side, sampled by the bench
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // handle_out
    logic [1:0]  m_tuser;          // status, freed

    // predictor copy of the table
    rct_pkg::handle_t tbl_handle [rct_pkg::ENTRIES];
    rct_pkg::count_t  tbl_count  [rct_pkg::ENTRIES];

    word_t       pending_words [$];
    result_t     owed_results  [$];
    logic [31:0] handle_pool   [POOL_SIZE];

    int    cycle_count = 0;
    int    fault_count = 0;
    int    s_gap       = 0;
    int    m_gap       = 0;
    bit    s_valid_nxt;
    word_t cur_word;

    reference_count_table_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // apply one accepted word to the table copy and queue the result it owes
    task automatic update_table(input word_t w);
        rct_pkg::handle_t nh;
        rct_pkg::handle_t sh;
        rct_pkg::handle_t dh;
        result_t          r;
        int               slot;
        nh = w.new_h;
        sh = w.src_h;
        dh = w.dst_h;
        r.handle_out = '0;
        r.status     = 1'b0;
        r.freed      = 1'b0;
        slot         = -1;
        if (w.kind == rct_pkg::KIND_ALLOC) begin
            // first slot with a zero count takes the handle
            for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
                if (slot < 0 && tbl_count[i] == '0) slot = i;
            end
            if (slot >= 0) begin
                tbl_handle[slot] = nh;
                tbl_count[slot]  = rct_pkg::count_t'(1);
                r.handle_out     = nh;
            end else begin
                r.status = 1'b1;
            end
        end else begin
            // release the first match of the source, null never matches
            if (sh != '0) begin
                for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
                    if (slot < 0 && tbl_handle[i] == sh) slot = i;
                end
                if (slot >= 0) begin
                    if (tbl_count[slot] != '0) tbl_count[slot] = tbl_count[slot] - 1'b1;
                    if (tbl_count[slot] == '0) begin
                        tbl_handle[slot] = '0;
                        r.freed          = 1'b1;
                    end
                end
            end
            // then retain every slot still holding the destination, saturating
            if (dh != '0) begin
                for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
                    if (tbl_handle[i] == dh && tbl_count[i] != rct_pkg::COUNT_MAX) begin
                        tbl_count[i] = tbl_count[i] + 1'b1;
                    end
                end
            end
            r.handle_out = dh;
        end
        owed_results.push_back(r);
    endtask

    task automatic add_word(input rct_pkg::kind_t k, input logic [31:0] n,
                            input logic [31:0] s, input logic [31:0] d, input bit hold);
        word_t w;
        w.kind           = k;
        w.new_h          = n;
        w.src_h          = s;
        w.dst_h          = d;
        w.hold_for_drain = hold;
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] pick_handle();
        return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // no idling once 150 or fewer words are pending, nor while cycle_count[9:8] is zero
    function automatic bit idling_allowed();
        return pending_words.size() > 150 && cycle_count[9:8] != 2'b00;
    endfunction

    task automatic report_fault(input string what, input result_t exp_r);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("mismatch (%s) at cycle %0d: expected handle %h status %b freed %b,",
                     what, cycle_count, exp_r.handle_out, exp_r.status, exp_r.freed);
            $display("    got handle %h status %b freed %b", m_tdata, m_tuser[0], m_tuser[1]);
        end
    endtask

    // driver: one nonblocking write of s_tvalid per edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap    = 0;
        end else begin
            s_valid_nxt = s_tvalid;
            if (s_tvalid && s_tready) begin
                update_table(cur_word);
                s_valid_nxt = 1'b0;
            end
            if (!s_valid_nxt) begin
                if (s_gap != 0) begin
                    s_gap = s_gap - 1;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].hold_for_drain && owed_results.size() != 0)) begin
                    if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                        s_gap = $urandom_range(1, 17);
                    end else begin
                        cur_word    = pending_words.pop_front();
                        s_valid_nxt = 1'b1;
                        s_tdata <= {cur_word.dst_h, cur_word.src_h, cur_word.new_h};
                        s_tuser <= cur_word.kind;
                    end
                end
            end
            s_tvalid <= s_valid_nxt;
        end
    end

    // monitor: stall bursts on tready, every accepted result checked in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    report_fault("no result owed", '{default: '0});
                end else if (m_tdata !== owed_results[0].handle_out ||
                             m_tuser[0] !== owed_results[0].status ||
                             m_tuser[1] !== owed_results[0].freed) begin
                    report_fault("wrong field", owed_results.pop_front());
                end else begin
                    void'(owed_results.pop_front());
                end
            end
            if (m_gap != 0) begin
                m_gap = m_gap - 1;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                m_gap = $urandom_range(1, 17);
            end
            m_tready <= (m_gap == 0);
        end
    end

    // cycle counter and hard stop
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int          sel;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] rnd;

        for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
            tbl_handle[i] = '0;
            tbl_count[i]  = '0;
        end

        // handles the random part draws from: the directed ones plus a few random
        handle_pool[0] = 32'hFFFF_FFFF;
        handle_pool[1] = 32'h0000_0001;
        handle_pool[2] = 32'h8000_0000;
        handle_pool[3] = 32'hA5A5_5A5A;
        handle_pool[4] = 32'h5A5A_A5A5;
        handle_pool[5] = 32'h1234_5678;
        handle_pool[6] = 32'hFEDC_BA98;
        handle_pool[7] = 32'h0F0F_F0F0;
        handle_pool[8] = 32'hF0F0_0F0F;
        handle_pool[9] = 32'h7777_7777;
        for (int i = 10; i < POOL_SIZE; i++) begin
            do rnd = $urandom; while (rnd == '0);
            handle_pool[i] = rnd;
        end

        // directed: extremes, null allocation, release to zero, equal source and destination
        add_word(rct_pkg::KIND_ALLOC,  32'hFFFF_FFFF, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h0000_0001, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h8000_0000, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h0000_0000, '0, '0, 1'b0);   // null slot stays taken
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // freed
        add_word(rct_pkg::KIND_ASSIGN, '0, '0, 32'h0000_0001, 1'b0);
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'h0000_0001, '0, 1'b0);
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'h8000_0000, 32'h0000_0001, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'hA5A5_5A5A, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h5A5A_A5A5, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h1234_5678, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'hFEDC_BA98, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h0F0F_F0F0, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'hF0F0_0F0F, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h7777_7777, '0, '0, 1'b0);   // table full
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'h1234_5678, 32'h1234_5678, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'hA5A5_5A5A, '0, '0, 1'b0);   // duplicate handle
        add_word(rct_pkg::KIND_ASSIGN, '0, '0, 32'hA5A5_5A5A, 1'b0);   // retains both copies
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'hA5A5_5A5A, '0, 1'b0);   // releases first only
        add_word(rct_pkg::KIND_ASSIGN, '0, 32'h3C3C_3C3C, 32'h3C3C_3C3C, 1'b0);
        add_word(rct_pkg::KIND_ASSIGN, 32'hFFFF_FFFF, '0, '0, 1'b0);
        add_word(rct_pkg::KIND_ALLOC,  32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        // drive handle 1 into saturation after a full drain, then release it to zero
        for (int i = 0; i < 260; i++) begin
            add_word(rct_pkg::KIND_ASSIGN, $urandom, '0, 32'h0000_0001, i == 0);
        end
        for (int i = 0; i < 255; i++) begin
            add_word(rct_pkg::KIND_ASSIGN, $urandom, 32'h0000_0001, '0, 1'b0);
        end

        // random traffic over the pool with a little noise
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                add_word(rct_pkg::KIND_ALLOC, pick_handle(), $urandom, $urandom, 1'b0);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 10)      src = '0;
                else if (sel < 15) src = $urandom;
                else               src = pick_handle();
                sel = $urandom_range(0, 99);
                if (sel < 20)      dst = '0;
                else if (sel < 25) dst = $urandom;
                else if (sel < 32) dst = src;
                else               dst = pick_handle();
                add_word(rct_pkg::KIND_ASSIGN, $urandom, src, dst, 1'b0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid) @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fault_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
